>>> rtl/core/rlpe_pkg.sv
package rlpe_pkg;

    localparam int ColorWidth  = 24;
    localparam int TickWidth   = 16;
    localparam int CfgIdxWidth = 3;
    localparam int QDepth      = 2;

    localparam logic [CfgIdxWidth-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_ONE_HIGH  = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_ZERO_LOW  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_LATCH_LOW = 3'd4;

    localparam logic [TickWidth-1:0] RST_ZERO_HIGH = 16'd6;
    localparam logic [TickWidth-1:0] RST_ONE_HIGH  = 16'd12;
    localparam logic [TickWidth-1:0] RST_ZERO_LOW  = 16'd40;
    localparam logic [TickWidth-1:0] RST_ONE_LOW   = 16'd40;
    localparam logic [TickWidth-1:0] RST_LATCH_LOW = 16'd1700;

    typedef struct packed {
        logic                  is_latch;
        logic [ColorWidth-1:0] color;
    } t_req;

    typedef struct packed {
        logic [TickWidth-1:0] zero_high;
        logic [TickWidth-1:0] one_high;
        logic [TickWidth-1:0] zero_low;
        logic [TickWidth-1:0] one_low;
        logic [TickWidth-1:0] latch_low;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } t_phase;

    // zero counts as one tick, then clamp to the tick counter range
    function automatic logic [TickWidth-1:0] fit_ticks(input logic [TickWidth-1:0] v,
                                                        input logic [TickWidth-1:0] max_ticks);
        logic [TickWidth-1:0] t;
        t = (v == '0) ? TickWidth'(1) : v;
        return (t > max_ticks) ? max_ticks : t;
    endfunction

endpackage

>>> rtl/core/rlpe_front.sv
module rlpe_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_req_type,
    input  logic [rlpe_pkg::ColorWidth-1:0] i_color,
    output logic                            o_push,
    output rlpe_pkg::t_req                  o_req,
    input  logic                            i_q_full
);
    import rlpe_pkg::*;

    logic r_valid;
    t_req r_req;
    logic accept;

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // latch items carry no colour
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.is_latch <= i_req_type;
            r_req.color    <= i_req_type ? '0 : i_color;
        end
    end

endmodule

>>> rtl/core/rlpe_queue.sv
module rlpe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rlpe_pkg::t_req i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rlpe_pkg::t_req o_req
);
    import rlpe_pkg::*;

    localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW = $clog2(QDepth + 1);

    t_req            r_mem [QDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QDepth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QDepth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

>>> rtl/core/rlpe_back.sv
module rlpe_back #(
    parameter int BITS_PER_LED = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rlpe_pkg::t_cfg                 i_cfg,
    input  logic                           i_q_valid,
    input  rlpe_pkg::t_req                 i_q_req,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_level,
    output logic [rlpe_pkg::TickWidth-1:0] o_dur,
    output logic                           o_last
);
    import rlpe_pkg::*;

    localparam int W    = BITS_PER_LED;
    localparam int CntW = $clog2(W + 1);

    t_phase               r_phase, n_phase;
    logic [W-1:0]         r_shift, n_shift;
    logic [CntW-1:0]      r_bits, n_bits;
    logic                 r_ov, n_ov;
    logic                 r_level, n_level;
    logic [TickWidth-1:0] r_dur, n_dur;
    logic                 r_last, n_last;
    logic [W-1:0]         load;
    logic                 adv;

    // extra high bits beyond the colour word go out as zeros
    assign load = W'({8'b0, i_q_req.color});
    assign adv  = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ov    <= 1'b0;
            r_bits  <= '0;
        end else begin
            r_phase <= n_phase;
            r_ov    <= n_ov;
            r_bits  <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_level <= n_level;
        r_dur   <= n_dur;
        r_last  <= n_last;
    end

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_ov    = r_ov;
        n_level = r_level;
        n_dur   = r_dur;
        n_last  = r_last;
        o_q_pop = 1'b0;
        if (adv) begin
            n_ov = 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_q_valid) begin
                        o_q_pop = 1'b1;
                        n_ov    = 1'b1;
                        if (i_q_req.is_latch) begin
                            n_level = 1'b0;
                            n_dur   = i_cfg.latch_low;
                            n_last  = 1'b1;
                        end else begin
                            n_shift = load;
                            n_bits  = CntW'(W);
                            n_level = 1'b1;
                            n_dur   = load[W-1] ? i_cfg.one_high : i_cfg.zero_high;
                            n_last  = 1'b0;
                            n_phase = PH_LOW;
                        end
                    end
                end
                PH_HIGH: begin
                    n_ov    = 1'b1;
                    n_level = 1'b1;
                    n_dur   = r_shift[W-1] ? i_cfg.one_high : i_cfg.zero_high;
                    n_last  = 1'b0;
                    n_phase = PH_LOW;
                end
                PH_LOW: begin
                    n_ov    = 1'b1;
                    n_level = 1'b0;
                    n_dur   = r_shift[W-1] ? i_cfg.one_low : i_cfg.zero_low;
                    n_last  = (r_bits == CntW'(1));
                    n_shift = r_shift << 1;
                    n_bits  = r_bits - CntW'(1);
                    n_phase = (r_bits == CntW'(1)) ? PH_IDLE : PH_HIGH;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_level = r_level;
    assign o_dur   = r_dur;
    assign o_last  = r_last;

endmodule

>>> rtl/core/rgb_led_pulse_encoder_top.sv
// channel   dir  handshake                       payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata colour, tuser request kind
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata level and duration, tlast
// cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_wdata
//
// a colour item gives 2*BITS_PER_LED segments, 48 at defaults, one per cycle unless stalled
// a latch item gives one segment; the segment serializer sets the rate
// a two-entry queue between intake and serializer keeps items flowing back to back
// reset is synchronous, active low, and restores the register defaults
// a stalled output holds its segment; intake accepts until queue and intake register fill
module rgb_led_pulse_encoder_top #(
    parameter int BITS_PER_LED     = 24,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [23:0]                       i_s_axis_tdata,  // color_word
    input  logic                              i_s_axis_tuser,  // req_type
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [23:0]                       o_m_axis_tdata,  // line_level, duration_ticks
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [rlpe_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [rlpe_pkg::TickWidth-1:0]    i_cfg_wdata
);
    import rlpe_pkg::*;

    localparam logic [TickWidth-1:0] MaxTicks = (TICK_COUNT_WIDTH >= TickWidth) ?
        {TickWidth{1'b1}} : TickWidth'((32'd1 << TICK_COUNT_WIDTH) - 32'd1);

    t_cfg                 r_cfg;
    t_req                 front_req;
    t_req                 q_req;
    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic                 level;
    logic [TickWidth-1:0] dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= fit_ticks(RST_ZERO_HIGH, MaxTicks);
            r_cfg.one_high  <= fit_ticks(RST_ONE_HIGH, MaxTicks);
            r_cfg.zero_low  <= fit_ticks(RST_ZERO_LOW, MaxTicks);
            r_cfg.one_low   <= fit_ticks(RST_ONE_LOW, MaxTicks);
            r_cfg.latch_low <= fit_ticks(RST_LATCH_LOW, MaxTicks);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZERO_HIGH: r_cfg.zero_high <= fit_ticks(i_cfg_wdata, MaxTicks);
                CFG_ONE_HIGH:  r_cfg.one_high  <= fit_ticks(i_cfg_wdata, MaxTicks);
                CFG_ZERO_LOW:  r_cfg.zero_low  <= fit_ticks(i_cfg_wdata, MaxTicks);
                CFG_ONE_LOW:   r_cfg.one_low   <= fit_ticks(i_cfg_wdata, MaxTicks);
                CFG_LATCH_LOW: r_cfg.latch_low <= fit_ticks(i_cfg_wdata, MaxTicks);
                default: begin
                end
            endcase
        end
    end

    rlpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_req_type (i_s_axis_tuser),
        .i_color    (i_s_axis_tdata),
        .o_push     (push),
        .o_req      (front_req),
        .i_q_full   (q_full)
    );

    rlpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    rlpe_back #(
        .BITS_PER_LED (BITS_PER_LED)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_req   (q_req),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_level   (level),
        .o_dur     (dur),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'b0, dur, level};

endmodule
